/* rtl/core/dsva_pkg.sv */
// ----------------------------------------------------------------------------
// dsva_pkg
// Types and constants shared by the scene vote aggregator and its channel
// interfaces.
// ----------------------------------------------------------------------------
package dsva_pkg;

  // Scene frequency that marks a backdoor scene.
  localparam logic [15:0] BACKDOOR_MARK = 16'hbacd;
  // Saturation limit of the user counters.
  localparam logic [7:0]  COUNT_MAX     = 8'hff;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_EXIT    = 2'd1,
    OP_SET     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_STATUS = 2'd0,
    ACT_VOTE   = 2'd1,
    ACT_FORCE  = 2'd2,
    ACT_AUTO   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_READY = 2'd1,
    STS_BAD_SCENE = 2'd2,
    STS_NO_BDOOR  = 2'd3
  } sts_e;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_SCENES    = 2'd1,
    CFG_BDOOR     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  scene_index;
    logic [15:0] new_freq;
    logic [3:0]  new_group;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] value;
    logic [3:0]  vote_group;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // One scene table entry.
  typedef struct packed {
    logic [15:0] freq;
    logic [3:0]  grp;
    logic [7:0]  users;
  } scene_t;

endpackage

/* rtl/core/dsva_in_if.sv */
// ----------------------------------------------------------------------------
// dsva_in_if
// Valid/ready channel that carries one operation to the aggregator.
// ----------------------------------------------------------------------------
interface dsva_in_if;
  logic               valid;
  logic               ready;
  dsva_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/dsva_out_if.sv */
// ----------------------------------------------------------------------------
// dsva_out_if
// Valid/ready channel that carries one result from the aggregator.
// ----------------------------------------------------------------------------
interface dsva_out_if;
  logic                valid;
  logic                ready;
  dsva_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/dfs_scene_vote_aggregator.sv */
// ----------------------------------------------------------------------------
// dfs_scene_vote_aggregator
// Scene table with per-group frequency voting and backdoor frequency control.
// ----------------------------------------------------------------------------
// The block works on one operation at a time. An accepted transaction first
// reads its scene entry from the scene table (a synchronous RAM with one read
// port, one write port and a registered read output), updates it and writes
// it back. Unless the operation is a backdoor request, the block then walks
// the scene table one entry per cycle to find the largest frequency among
// scenes of the affected group that have users, compares it with the group's
// last vote and queues a vote when it changed. The walk over the single RAM
// read port makes the time per operation grow with the number of scenes in
// use (at most MAX_SCENES); the next operation is accepted only after the
// last result has been queued. A backdoor request skips the walk and the
// vote, and an operation that fails the enable or scene check, or carries
// the unused opcode, goes straight to its status result. Results (one or two
// per operation, the final one flagged by last) go to a two-entry output
// queue, so the next operation is taken while earlier results still wait for
// the consumer. When that queue is full, the sequencer holds in its emit
// states for as long as the consumer stalls. User counts are cleared at reset
// through one valid bit per entry, so no clearing pass is needed; frequency
// and group of a scene hold no defined value until a set operation writes
// them. The user must write configuration only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module dfs_scene_vote_aggregator #(
  parameter int MAX_SCENES = 32,
  parameter int NUM_GROUPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Operation and result channels.
  dsva_in_if.sink     in_i,
  dsva_out_if.source  out_o
);
  import dsva_pkg::*;

  // Address width of the scene table and width of a scene count.
  localparam int IW = (MAX_SCENES > 1) ? $clog2(MAX_SCENES) : 1;
  localparam int CW = $clog2(MAX_SCENES + 1);
  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_VOTE,
    ST_EM_VOTE,
    ST_EM_CMD,
    ST_EM_STAT
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic        enable_q;
  logic [5:0]  scenes_q;
  logic [15:0] bdoor_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      scenes_q     <= '0;
      bdoor_freq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: enable_q     <= cfg_data_i[0];
        CFG_SCENES: scenes_q     <= cfg_data_i[5:0];
        CFG_BDOOR:  bdoor_freq_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Number of scene entries taken into account.
  logic [8:0]    scenes9;
  logic [CW-1:0] lim;

  assign scenes9 = {3'b000, scenes_q};
  assign lim     = (scenes9 > 9'(MAX_SCENES)) ? CW'(MAX_SCENES) : scenes9[CW-1:0];

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  state_e        state_q;
  logic [1:0]    op_q;
  logic [IW-1:0] addr_q;
  logic [15:0]   nf_q;
  logic [3:0]    ng_q;
  logic [3:0]    vgrp_q;
  logic [CW-1:0] cnt_q;
  logic          chk_q;
  logic          chk_vld_q;
  logic [15:0]   max_q;
  logic          vote_pend_q;
  logic [15:0]   vote_val_q;
  logic          cmd_pend_q;
  logic [1:0]    cmd_act_q;
  logic [15:0]   cmd_val_q;
  logic [1:0]    status_q;
  logic [7:0]    bd_users_q;
  logic [15:0]   last_vote_q [NUM_GROUPS];

  // --------------------------------------------------------------------------
  // Scene table: RAM plus one valid bit per entry for the user count reset.
  // --------------------------------------------------------------------------
  scene_t              scene_mem [MAX_SCENES];
  scene_t              rd_data_q;
  logic [MAX_SCENES-1:0] vld_q;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  scene_t              wr_data;
  logic [8:0]          in_idx9;

  assign in_idx9 = {4'b0000, in_i.payload.scene_index};
  assign rd_addr = (state_q == ST_SCAN) ? cnt_q[IW-1:0] : in_idx9[IW-1:0];
  assign mem_we  = (state_q == ST_MOD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      scene_mem[addr_q] <= wr_data;
    end
    rd_data_q <= scene_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // Entry read for the operation; an entry never written has no users.
  scene_t cur;
  logic   is_bd;

  always_comb begin
    cur = rd_data_q;
    if (!vld_q[addr_q]) begin
      cur.users = '0;
    end
  end

  assign is_bd = (cur.freq == BACKDOOR_MARK);

  always_comb begin
    wr_data = cur;
    unique case (op_q)
      OP_REQUEST: if (cur.users != COUNT_MAX) wr_data.users = cur.users + 8'd1;
      OP_EXIT:    if (cur.users != '0) wr_data.users = cur.users - 8'd1;
      default: begin
        wr_data.freq = nf_q;
        wr_data.grp  = ng_q;
      end
    endcase
  end

  // Scan compare on the entry that arrives from the RAM.
  logic scan_hit;

  assign scan_hit = chk_q && chk_vld_q && (rd_data_q.users != '0) &&
                    (rd_data_q.grp == vgrp_q) && (rd_data_q.freq > max_q);

  // Slot of the group's last vote: group modulo the group count.
  logic [GW-1:0] slot;

  always_comb begin
    slot = '0;
    for (int k = 0; k < 16; k++) begin
      if (vgrp_q == 4'(k)) begin
        slot = GW'(k % NUM_GROUPS);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output queue, two entries deep.
  // --------------------------------------------------------------------------
  out_item_t oq_q [2];
  logic      oq_wr_q;
  logic      oq_rd_q;
  logic [1:0] oq_cnt_q;
  logic      oq_full;
  logic      push;
  logic      pop;
  out_item_t push_item;
  logic      need_stat;

  assign oq_full   = (oq_cnt_q == 2'd2);
  assign pop       = out_o.valid && out_o.ready;
  assign need_stat = (status_q != STS_OK) || (!vote_pend_q && !cmd_pend_q);

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    unique case (state_q)
      ST_EM_VOTE: begin
        push                 = vote_pend_q && !oq_full;
        push_item.action     = ACT_VOTE;
        push_item.value      = vote_val_q;
        push_item.vote_group = vgrp_q;
        push_item.last       = !cmd_pend_q && !need_stat;
      end
      ST_EM_CMD: begin
        push             = cmd_pend_q && !oq_full;
        push_item.action = cmd_act_q;
        push_item.value  = cmd_val_q;
        push_item.last   = !need_stat;
      end
      ST_EM_STAT: begin
        push             = need_stat && !oq_full;
        push_item.action = ACT_STATUS;
        push_item.status = status_q;
        push_item.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[oq_wr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (push) oq_wr_q <= !oq_wr_q;
      if (pop)  oq_rd_q <= !oq_rd_q;
      unique case ({push, pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  assign out_o.valid   = (oq_cnt_q != '0);
  assign out_o.payload = oq_q[oq_rd_q];

  // --------------------------------------------------------------------------
  // Operation sequencer.
  // --------------------------------------------------------------------------
  logic accept;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_REQUEST;
      addr_q      <= '0;
      nf_q        <= '0;
      ng_q        <= '0;
      vgrp_q      <= '0;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      chk_vld_q   <= 1'b0;
      max_q       <= '0;
      vote_pend_q <= 1'b0;
      vote_val_q  <= '0;
      cmd_pend_q  <= 1'b0;
      cmd_act_q   <= ACT_STATUS;
      cmd_val_q   <= '0;
      status_q    <= STS_OK;
      bd_users_q  <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        last_vote_q[g] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q        <= in_i.payload.operation;
            addr_q      <= in_idx9[IW-1:0];
            nf_q        <= in_i.payload.new_freq;
            ng_q        <= in_i.payload.new_group;
            vote_pend_q <= 1'b0;
            cmd_pend_q  <= 1'b0;
            if (!enable_q) begin
              status_q <= STS_NOT_READY;
              state_q  <= ST_EM_STAT;
            end else if (in_i.payload.operation == OP_NONE) begin
              status_q <= STS_OK;
              state_q  <= ST_EM_STAT;
            end else if (in_idx9 >= 9'(lim)) begin
              status_q <= STS_BAD_SCENE;
              state_q  <= ST_EM_STAT;
            end else begin
              status_q <= STS_OK;
              state_q  <= ST_MOD;
            end
          end
        end

        ST_MOD: begin
          // The entry is written back in this cycle; the walk starts after it.
          vgrp_q <= (op_q == OP_SET) ? ng_q : cur.grp;
          cnt_q  <= '0;
          chk_q  <= 1'b0;
          max_q  <= '0;
          // A backdoor request counts its user but casts no vote.
          state_q <= (op_q == OP_REQUEST && is_bd) ? ST_EM_VOTE : ST_SCAN;
          if (op_q == OP_REQUEST && is_bd) begin
            if (bdoor_freq_q == '0) begin
              status_q <= STS_NO_BDOOR;
            end else begin
              if (bd_users_q == '0) begin
                cmd_pend_q <= 1'b1;
                cmd_act_q  <= ACT_FORCE;
                cmd_val_q  <= bdoor_freq_q;
              end
              if (bd_users_q != COUNT_MAX) bd_users_q <= bd_users_q + 8'd1;
            end
          end else if (op_q == OP_EXIT && is_bd) begin
            // The auto enable command follows the vote of this exit.
            if (bdoor_freq_q == '0) begin
              status_q <= STS_NO_BDOOR;
            end else if (bd_users_q != '0) begin
              bd_users_q <= bd_users_q - 8'd1;
              if (bd_users_q == 8'd1) begin
                cmd_pend_q <= 1'b1;
                cmd_act_q  <= ACT_AUTO;
                cmd_val_q  <= '0;
              end
            end
          end
        end

        ST_SCAN: begin
          if (scan_hit) max_q <= rd_data_q.freq;
          if (cnt_q < lim) begin
            chk_q     <= 1'b1;
            chk_vld_q <= vld_q[cnt_q[IW-1:0]];
            cnt_q     <= cnt_q + CW'(1);
          end else begin
            chk_q   <= 1'b0;
            state_q <= ST_VOTE;
          end
        end

        ST_VOTE: begin
          if (max_q != last_vote_q[slot]) begin
            last_vote_q[slot] <= max_q;
            vote_pend_q       <= 1'b1;
            vote_val_q        <= max_q;
          end
          state_q <= ST_EM_VOTE;
        end

        ST_EM_VOTE: begin
          if (!vote_pend_q || push) state_q <= ST_EM_CMD;
        end

        ST_EM_CMD: begin
          if (!cmd_pend_q || push) state_q <= ST_EM_STAT;
        end

        ST_EM_STAT: begin
          if (!need_stat || push) state_q <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scene vote aggregator. Operations go in over the
// operation channel while the bench tracks the scene table, user counts,
// group votes and backdoor users itself. Every result transaction is compared
// field by field with the oldest outstanding prediction. A short table of hand
// picked operations comes first. A long backdoor run drives both user counters
// into saturation, and random phases under changing register settings follow.
// ----------------------------------------------------------------------------
module tb;
  import dsva_pkg::*;

  // One row of the opening table: either a register write or an operation.
  // A fixed row carries its expected status directly; those rows are only
  // rejections and the unused opcode, which leave the scene table untouched.
  typedef struct {
    bit          is_reg;
    cfg_e        reg_sel;
    logic [15:0] reg_val;
    in_item_t    op;
    bit          fixed;
    sts_e        fixed_sts;
  } opening_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  dsva_in_if  op_if ();
  dsva_out_if res_if ();

  dfs_scene_vote_aggregator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (op_if),
    .out_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the block: registers, scene table, votes and backdoor users.
  // --------------------------------------------------------------------------
  logic        cfg_enabled;
  logic [5:0]  cfg_scenes;
  logic [15:0] cfg_bdoor;

  logic [15:0] shadow_freq  [32];
  logic [3:0]  scene_grp    [32];
  logic [7:0]  scene_users  [32];
  bit          scene_loaded [32];
  logic [15:0] group_vote   [16];
  logic [7:0]  bdoor_users;

  out_item_t   pending_actions[$];
  int unsigned mismatches;
  bit          calm;
  int unsigned ready_hold;
  out_item_t   oldest;

  function automatic int unsigned scene_limit();
    return (cfg_scenes > 6'd32) ? 32 : cfg_scenes;
  endfunction

  function automatic out_item_t make_result(act_e a, logic [15:0] v, logic [3:0] g,
                                            sts_e s, logic l);
    out_item_t r;
    r.action     = a;
    r.value      = v;
    r.vote_group = g;
    r.status     = s;
    r.last       = l;
    return r;
  endfunction

  function automatic in_item_t scene_op(op_e o, logic [4:0] i, logic [15:0] f,
                                        logic [3:0] g);
    in_item_t it;
    it.operation   = o;
    it.scene_index = i;
    it.new_freq    = f;
    it.new_group   = g;
    return it;
  endfunction

  task automatic apply_reg(input cfg_e r, input logic [15:0] v);
    case (r)
      CFG_ENABLE: cfg_enabled = v[0];
      CFG_SCENES: cfg_scenes  = v[5:0];
      CFG_BDOOR:  cfg_bdoor   = v;
      default: ;
    endcase
  endtask

  // Find the highest frequency among the group's scenes that have users. A
  // change against the group's last vote becomes a vote and is recorded.
  task automatic rescan_group(input logic [3:0] grp, inout int n);
    logic [15:0] top;
    int unsigned i;
    top = 16'd0;
    for (i = 0; i < scene_limit(); i++) begin
      if (scene_users[i] != 8'd0 && shadow_freq[i] > top && scene_grp[i] == grp)
        top = shadow_freq[i];
    end
    if (top != group_vote[grp]) begin
      group_vote[grp] = top;
      pending_actions.push_back(make_result(ACT_VOTE, top, grp, STS_OK, 1'b0));
      n++;
    end
  endtask

  // Predict the results of one accepted operation and update the shadow state.
  task automatic forecast_actions(input in_item_t it);
    int         n;
    sts_e       sts;
    op_e        op;
    logic [4:0] idx;
    n   = 0;
    sts = STS_OK;
    op  = op_e'(it.operation);
    idx = it.scene_index;
    if (!cfg_enabled) begin
      sts = STS_NOT_READY;
    end else if (op != OP_NONE) begin
      if (idx >= scene_limit()) begin
        sts = STS_BAD_SCENE;
      end else begin
        case (op)
          OP_REQUEST: begin
            if (scene_users[idx] != COUNT_MAX) scene_users[idx]++;
            // A backdoor request never votes; it forces the frequency on the
            // first user only.
            if (shadow_freq[idx] == BACKDOOR_MARK) begin
              if (cfg_bdoor == 16'd0) begin
                sts = STS_NO_BDOOR;
              end else begin
                if (bdoor_users == 8'd0) begin
                  pending_actions.push_back(make_result(ACT_FORCE, cfg_bdoor, 4'd0,
                                                        STS_OK, 1'b0));
                  n++;
                end
                if (bdoor_users != COUNT_MAX) bdoor_users++;
              end
            end else begin
              rescan_group(scene_grp[idx], n);
            end
          end
          OP_EXIT: begin
            if (scene_users[idx] != 8'd0) scene_users[idx]--;
            rescan_group(scene_grp[idx], n);
            // The backdoor bookkeeping runs after the vote.
            if (shadow_freq[idx] == BACKDOOR_MARK) begin
              if (cfg_bdoor == 16'd0) begin
                sts = STS_NO_BDOOR;
              end else if (bdoor_users != 8'd0) begin
                bdoor_users--;
                if (bdoor_users == 8'd0) begin
                  pending_actions.push_back(make_result(ACT_AUTO, 16'd0, 4'd0,
                                                        STS_OK, 1'b0));
                  n++;
                end
              end
            end
          end
          default: begin
            // Only the newly stored group is rescanned.
            shadow_freq[idx]  = it.new_freq;
            scene_grp[idx]    = it.new_group;
            scene_loaded[idx] = 1'b1;
            rescan_group(it.new_group, n);
          end
        endcase
      end
    end
    if (n == 0 || sts != STS_OK)
      pending_actions.push_back(make_result(ACT_STATUS, 16'd0, 4'd0, sts, 1'b1));
    else
      pending_actions[pending_actions.size() - 1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Operation side. The payload changes at the falling edge, and acceptance is
  // seen at the rising edge, where the prediction is queued.
  // --------------------------------------------------------------------------
  task automatic issue(input in_item_t it, input bit fixed, input sts_e fixed_sts);
    op_if.payload = it;
    op_if.valid   = 1'b1;
    do @(posedge clk_i); while (!op_if.ready);
    if (fixed)
      pending_actions.push_back(make_result(ACT_STATUS, 16'd0, 4'd0, fixed_sts, 1'b1));
    else
      forecast_actions(it);
    @(negedge clk_i);
    // Outside the calm phase, about one transaction in four is followed by an idle burst with valid low.
    if (!calm && $urandom_range(3) == 0) begin
      op_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  // Hold off new operations until every predicted result has come back.
  task automatic settle();
    op_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_reg(input cfg_e r, input logic [15:0] v);
    settle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = r;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    apply_reg(r, v);
  endtask

  // Random operation. Most are sets, requests and exits on valid scenes; the
  // rest are unused opcodes and scene numbers past the table. A request or an
  // exit that would read a never-loaded scene becomes a set of that scene.
  function automatic in_item_t draw_scene_op();
    in_item_t    it;
    int unsigned lim;
    int unsigned pick;
    lim  = scene_limit();
    pick = $urandom_range(99);
    it   = scene_op(OP_NONE, 5'($urandom_range(31)), 16'($urandom_range(65535)),
                    4'($urandom_range(15)));
    if (pick < 6) return it;
    if (lim != 0 && pick >= 12) it.scene_index = 5'($urandom_range(lim - 1));
    pick = $urandom_range(99);
    if (pick < 35)      it.operation = OP_SET;
    else if (pick < 70) it.operation = OP_REQUEST;
    else                it.operation = OP_EXIT;
    if (it.operation != OP_SET && cfg_enabled && it.scene_index < lim &&
        !scene_loaded[it.scene_index])
      it.operation = OP_SET;
    if (it.operation == OP_SET) begin
      // A small pool of frequencies makes ties and shifting maxima common.
      case ($urandom_range(7))
        0:       it.new_freq = BACKDOOR_MARK;
        1:       it.new_freq = 16'hffff;
        2:       it.new_freq = 16'h0000;
        3, 4, 5: it.new_freq = 16'($urandom_range(1, 4) * 1000);
        default: it.new_freq = 16'($urandom_range(65535));
      endcase
      if ($urandom_range(3) != 0)
        it.new_group = {1'($urandom_range(1)), 1'b0, 2'($urandom_range(3))};
    end
    return it;
  endfunction

  function automatic opening_row_t reg_row(cfg_e r, logic [15:0] v);
    opening_row_t row;
    row         = '{default: '0, reg_sel: CFG_ENABLE, fixed_sts: STS_OK};
    row.is_reg  = 1'b1;
    row.reg_sel = r;
    row.reg_val = v;
    return row;
  endfunction

  function automatic opening_row_t op_row(op_e o, logic [4:0] i, logic [15:0] f,
                                          logic [3:0] g);
    opening_row_t row;
    row    = '{default: '0, reg_sel: CFG_ENABLE, fixed_sts: STS_OK};
    row.op = scene_op(o, i, f, g);
    return row;
  endfunction

  function automatic opening_row_t fixed_row(op_e o, logic [4:0] i, logic [15:0] f,
                                             logic [3:0] g, sts_e s);
    opening_row_t row;
    row           = op_row(o, i, f, g);
    row.fixed     = 1'b1;
    row.fixed_sts = s;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Result side. Ready drops in random bursts except in the last phase. Each
  // result transaction is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (calm) begin
      res_if.ready = 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
      res_if.ready = 1'b0;
    end else if ($urandom_range(5) == 0) begin
      ready_hold   = $urandom_range(12);
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_actions.size() == 0) begin
        $error("result with nothing outstanding: action %0d value %0h status %0d",
               res_if.payload.action, res_if.payload.value, res_if.payload.status);
        mismatches++;
      end else begin
        oldest = pending_actions.pop_front();
        check_field("action", oldest.action, res_if.payload.action);
        check_field("value", oldest.value, res_if.payload.value);
        check_field("vote_group", oldest.vote_group, res_if.payload.vote_group);
        check_field("status", oldest.status, res_if.payload.status);
        check_field("last", oldest.last, res_if.payload.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    opening_row_t opening[$];
    int           phase;
    int           count;
    logic [5:0]   scenes;
    logic [15:0]  bdoor;
    logic         enable;
    logic [3:0]   bdoor_grp;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ENABLE;
    cfg_data_i    = 16'd0;
    op_if.valid   = 1'b0;
    op_if.payload = '0;
    res_if.ready  = 1'b0;
    calm          = 1'b0;
    ready_hold    = 0;
    mismatches    = 0;
    cfg_enabled   = 1'b0;
    cfg_scenes    = 6'd0;
    cfg_bdoor     = 16'd0;
    bdoor_users   = 8'd0;
    for (int i = 0; i < 32; i++) begin
      shadow_freq[i]  = 16'd0;
      scene_grp[i]    = 4'd0;
      scene_users[i]  = 8'd0;
      scene_loaded[i] = 1'b0;
    end
    for (int g = 0; g < 16; g++) group_vote[g] = 16'd0;

    // Opening table. It starts with the block still disabled after reset,
    // then covers an empty table, the unused opcode, the field extremes,
    // votes rising and falling within a group, an exit below zero users, a
    // set that moves a scene with users to a new group, and the backdoor
    // both without and with a configured frequency.
    opening.push_back(fixed_row(OP_REQUEST, 5'd0, 16'd0, 4'd0, STS_NOT_READY));
    opening.push_back(fixed_row(OP_SET, 5'd31, 16'hffff, 4'hf, STS_NOT_READY));
    opening.push_back(reg_row(CFG_ENABLE, 16'd1));
    opening.push_back(reg_row(CFG_SCENES, 16'd0));
    opening.push_back(reg_row(CFG_BDOOR, 16'd0));
    opening.push_back(reg_row(CFG_UNUSED, 16'hffff));
    opening.push_back(fixed_row(OP_REQUEST, 5'd0, 16'd0, 4'd0, STS_BAD_SCENE));
    opening.push_back(fixed_row(OP_NONE, 5'd31, 16'hffff, 4'hf, STS_OK));
    opening.push_back(reg_row(CFG_SCENES, 16'd32));
    opening.push_back(op_row(OP_SET, 5'd31, 16'hffff, 4'hf));
    opening.push_back(op_row(OP_REQUEST, 5'd31, 16'd0, 4'd0));
    opening.push_back(op_row(OP_SET, 5'd0, 16'd0, 4'd0));
    opening.push_back(op_row(OP_REQUEST, 5'd0, 16'd0, 4'd0));
    opening.push_back(op_row(OP_SET, 5'd1, 16'd1000, 4'd8));
    opening.push_back(op_row(OP_REQUEST, 5'd1, 16'd0, 4'd0));
    opening.push_back(op_row(OP_SET, 5'd2, 16'd2000, 4'd8));
    opening.push_back(op_row(OP_REQUEST, 5'd2, 16'd0, 4'd0));
    opening.push_back(op_row(OP_EXIT, 5'd2, 16'd0, 4'd0));
    opening.push_back(op_row(OP_EXIT, 5'd2, 16'd0, 4'd0));
    opening.push_back(op_row(OP_SET, 5'd1, 16'd500, 4'd8));
    opening.push_back(op_row(OP_SET, 5'd3, BACKDOOR_MARK, 4'd3));
    opening.push_back(op_row(OP_REQUEST, 5'd3, 16'd0, 4'd0));
    opening.push_back(op_row(OP_EXIT, 5'd3, 16'd0, 4'd0));
    opening.push_back(reg_row(CFG_BDOOR, 16'hffff));
    opening.push_back(op_row(OP_REQUEST, 5'd3, 16'd0, 4'd0));
    opening.push_back(op_row(OP_REQUEST, 5'd3, 16'd0, 4'd0));
    opening.push_back(op_row(OP_EXIT, 5'd3, 16'd0, 4'd0));
    opening.push_back(op_row(OP_EXIT, 5'd3, 16'd0, 4'd0));
    opening.push_back(reg_row(CFG_SCENES, 16'd63));
    opening.push_back(op_row(OP_SET, 5'd31, 16'd7, 4'd14));
    opening.push_back(op_row(OP_EXIT, 5'd31, 16'd0, 4'd0));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (opening[r]) begin
      if (opening[r].is_reg)
        write_reg(opening[r].reg_sel, opening[r].reg_val);
      else
        issue(opening[r].op, opening[r].fixed, opening[r].fixed_sts);
    end

    // Backdoor saturation: more requests than either user counter can hold,
    // then a short run of exits that works down from the clipped top value.
    bdoor_grp = 4'($urandom_range(15));
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_SCENES, 16'd1);
    write_reg(CFG_BDOOR, 16'($urandom_range(1, 65535)));
    issue(scene_op(OP_SET, 5'd0, BACKDOOR_MARK, bdoor_grp), 1'b0, STS_OK);
    repeat (257)
      issue(scene_op(OP_REQUEST, 5'd0, 16'($urandom_range(65535)),
                     4'($urandom_range(15))), 1'b0, STS_OK);
    repeat (24)
      issue(scene_op(OP_EXIT, 5'd0, 16'($urandom_range(65535)),
                     4'($urandom_range(15))), 1'b0, STS_OK);

    // Random phases under changing register settings. The first uses the
    // full table and the top backdoor frequency; the last runs without random
    // idle bursts on either side.
    for (phase = 0; phase < 5; phase++) begin
      enable = ($urandom_range(7) != 0) || phase == 0 || phase == 4;
      case ($urandom_range(5))
        0:       scenes = 6'd63;
        1:       scenes = 6'd32;
        2:       scenes = 6'd0;
        default: scenes = 6'($urandom_range(1, 12));
      endcase
      case ($urandom_range(3))
        0:       bdoor = 16'd0;
        1:       bdoor = 16'hffff;
        default: bdoor = 16'($urandom_range(65535));
      endcase
      if (phase == 0) begin
        scenes = 6'd32;
        bdoor  = 16'hffff;
      end
      write_reg(CFG_ENABLE, {15'd0, enable});
      write_reg(CFG_SCENES, {10'd0, scenes});
      write_reg(CFG_BDOOR, bdoor);
      if (phase == 4) calm = 1'b1;
      count = enable ? 40 : 10;
      repeat (count) begin
        issue(draw_scene_op(), 1'b0, STS_OK);
        // Now and then wait for every outstanding result before going on.
        if ($urandom_range(39) == 0) settle();
      end
    end

    op_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pending_actions.size() == 0)
      $display("dfs_scene_vote_aggregator: match");
    else
      $display("dfs_scene_vote_aggregator: mismatch");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #1500000;
    $display("dfs_scene_vote_aggregator: mismatch");
    $finish;
  end

endmodule

/* dfs_scene_vote_aggregator.f */
rtl/core/dsva_pkg.sv
rtl/core/dsva_in_if.sv
rtl/core/dsva_out_if.sv
rtl/core/dfs_scene_vote_aggregator.sv
verif/tb.sv
